>>> src/hsfd_pkg.sv
// Package for the humidity sensor frame decoder.
// Holds the byte position codes, status codes, the frame record and the CRC-8 step.
// No dependencies.
`default_nettype none

package hsfd_pkg;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;

  localparam logic [2:0] POS_T_HI  = 3'd0;
  localparam logic [2:0] POS_T_LO  = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_HI  = 3'd3;
  localparam logic [2:0] POS_H_LO  = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_T_CRC   = 2'd1;
  localparam logic [1:0] STATUS_H_CRC   = 2'd2;

  localparam logic [14:0] TempScale  = 15'd17500;
  localparam logic [13:0] HumScale   = 14'd10000;
  localparam logic [15:0] TempOffset = 16'd4500;

  typedef struct packed {
    logic [15:0] temperature_word;
    logic [15:0] humidity_word;
    logic [1:0]  status;
  } frame_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/hsfd_if.sv
// Handshake interfaces for the humidity sensor frame decoder.
// Byte input channel and result output channel; depends on nothing.
`default_nettype none

interface hsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface hsfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] temperature_centi;
  logic        [13:0] humidity_centi;
  logic        [1:0]  status;

  modport source (output valid, output temperature_centi, output humidity_centi,
                  output status, input ready);
  modport sink (input valid, input temperature_centi, input humidity_centi,
                input status, output ready);
endinterface

`default_nettype wire

>>> src/hsfd_framer.sv
// Frame tracker: byte position, running CRC-8 and raw word capture.
// Emits one registered frame record per complete frame; uses hsfd_pkg.
`default_nettype none

module hsfd_framer (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          byte_valid_i,
  output logic               byte_ready_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          frame_start_i,
  output logic               frame_valid_o,
  input  wire logic          frame_ready_i,
  output hsfd_pkg::frame_t   frame_o
);
  import hsfd_pkg::*;

  logic [2:0]  pos_q, pos_d, pos;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  high_q, high_d;
  logic [15:0] temp_word_q, temp_word_d;
  logic [15:0] hum_word_q, hum_word_d;
  logic        temp_bad_q, temp_bad_d;
  logic        frame_valid_q;
  frame_t      frame_q;
  logic        accept;
  logic        emit;

  assign byte_ready_o = !frame_valid_q || frame_ready_i;
  assign accept       = byte_valid_i && byte_ready_o;
  assign pos          = frame_start_i ? POS_T_HI : pos_q;

  always_comb begin
    pos_d       = pos_q;
    crc_d       = crc_q;
    high_d      = high_q;
    temp_word_d = temp_word_q;
    hum_word_d  = hum_word_q;
    temp_bad_d  = temp_bad_q;
    emit        = 1'b0;
    case (pos)
      POS_T_HI, POS_H_HI: begin
        crc_d  = crc8_update(CrcInit, data_byte_i);
        high_d = data_byte_i;
        pos_d  = pos + 3'd1;
      end
      POS_T_LO: begin
        crc_d       = crc8_update(crc_q, data_byte_i);
        temp_word_d = {high_q, data_byte_i};
        pos_d       = POS_T_CRC;
      end
      POS_T_CRC: begin
        temp_bad_d = (crc_q != data_byte_i);
        pos_d      = POS_H_HI;
      end
      POS_H_LO: begin
        crc_d      = crc8_update(crc_q, data_byte_i);
        hum_word_d = {high_q, data_byte_i};
        pos_d      = POS_H_CRC;
      end
      POS_H_CRC: begin
        emit  = 1'b1;
        pos_d = POS_T_HI;
      end
      default: begin
        pos_d = POS_T_HI;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= POS_T_HI;
      crc_q         <= CrcInit;
      temp_bad_q    <= 1'b0;
      frame_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q      <= pos_d;
        crc_q      <= crc_d;
        temp_bad_q <= temp_bad_d;
      end
      if (accept) begin
        frame_valid_q <= emit;
      end else if (frame_ready_i) begin
        frame_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      high_q      <= high_d;
      temp_word_q <= temp_word_d;
      hum_word_q  <= hum_word_d;
    end
    if (accept && emit) begin
      frame_q.temperature_word <= temp_word_q;
      frame_q.humidity_word    <= hum_word_q;
      if (temp_bad_q) begin
        frame_q.status <= STATUS_T_CRC;
      end else if (crc_q != data_byte_i) begin
        frame_q.status <= STATUS_H_CRC;
      end else begin
        frame_q.status <= STATUS_OK;
      end
    end
  end

  assign frame_valid_o = frame_valid_q;
  assign frame_o       = frame_q;

endmodule

`default_nettype wire

>>> src/hsfd_convert.sv
// Scaling of the raw words to hundredths and the result register.
// Division by 65535 is done exactly with an add-and-shift; uses hsfd_pkg.
`default_nettype none

module hsfd_convert (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               frame_valid_i,
  output logic                    frame_ready_o,
  input  wire hsfd_pkg::frame_t   frame_i,
  output logic                    result_valid_o,
  input  wire logic               result_ready_i,
  output logic signed [14:0]      temperature_centi_o,
  output logic        [13:0]      humidity_centi_o,
  output logic        [1:0]       status_o
);
  import hsfd_pkg::*;

  logic [31:0] temp_prod, temp_sum;
  logic [31:0] hum_prod, hum_sum;
  logic [15:0] temp_quot, temp_off;
  logic [15:0] hum_quot;

  logic               valid_q;
  logic signed [14:0] temp_q;
  logic        [13:0] hum_q;
  logic        [1:0]  status_q;
  logic               load;

  // floor(x / 65535) = ((x + 1) + ((x + 1) >> 16)) >> 16 for the ranges used here.
  always_comb begin
    temp_prod = 32'(frame_i.temperature_word) * 32'(TempScale) + 32'd1;
    temp_sum  = temp_prod + (temp_prod >> 16);
    temp_quot = temp_sum[31:16];
    temp_off  = temp_quot - TempOffset;
    hum_prod  = 32'(frame_i.humidity_word) * 32'(HumScale) + 32'd1;
    hum_sum   = hum_prod + (hum_prod >> 16);
    hum_quot  = hum_sum[31:16];
  end

  assign frame_ready_o = !valid_q || result_ready_i;
  assign load          = frame_valid_i && frame_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (frame_ready_o) begin
      valid_q <= frame_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      temp_q   <= $signed(temp_off[14:0]);
      hum_q    <= hum_quot[13:0];
      status_q <= frame_i.status;
    end
  end

  assign result_valid_o      = valid_q;
  assign temperature_centi_o = temp_q;
  assign humidity_centi_o    = hum_q;
  assign status_o            = status_q;

endmodule

`default_nettype wire

>>> src/humidity_sensor_frame_decoder.sv
// Top level of the humidity sensor frame decoder.
// Instantiates hsfd_framer and hsfd_convert; uses hsfd_pkg and the hsfd_if interfaces.
`default_nettype none

// Takes one byte of the six-byte sensor reply per cycle and gives one result per
// complete frame: temperature and humidity in hundredths, plus a CRC status in
// which a temperature check failure wins over a humidity one. A byte with
// frame_start set always begins a new frame and drops any partial one. The block
// accepts one byte every cycle while results are taken. When a result waits,
// bytes still flow until the next frame is complete in the frame register; the
// input then stalls until the waiting result is taken. After the sixth byte is
// accepted, the result passes the frame register, behind the compare with the
// running CRC-8, and then the result register, behind the constant multiply and
// the exact divide-by-65535 adder.
module humidity_sensor_frame_decoder (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hsfd_in_if.sink     data_i,
  hsfd_out_if.source  result_o
);
  import hsfd_pkg::*;

  logic   frame_valid;
  logic   frame_ready;
  frame_t frame;

  hsfd_framer u_framer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (data_i.valid),
    .byte_ready_o  (data_i.ready),
    .data_byte_i   (data_i.data_byte),
    .frame_start_i (data_i.frame_start),
    .frame_valid_o (frame_valid),
    .frame_ready_i (frame_ready),
    .frame_o       (frame)
  );

  hsfd_convert u_convert (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .frame_valid_i       (frame_valid),
    .frame_ready_o       (frame_ready),
    .frame_i             (frame),
    .result_valid_o      (result_o.valid),
    .result_ready_i      (result_o.ready),
    .temperature_centi_o (result_o.temperature_centi),
    .humidity_centi_o    (result_o.humidity_centi),
    .status_o            (result_o.status)
  );

endmodule

`default_nettype wire

>>> src/hsfd_checker.sv
// Port-level checks for the humidity sensor frame decoder.
// Bound to humidity_sensor_frame_decoder; depends on hsfd_pkg.
`default_nettype none

module hsfd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic signed [14:0] temperature_centi_i,
  input wire logic        [13:0] humidity_centi_i,
  input wire logic        [1:0]  status_i
);
  import hsfd_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == STATUS_OK || status_i == STATUS_T_CRC ||
                     status_i == STATUS_H_CRC))
    else $error("Result status carries an undefined code.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (humidity_centi_i <= 14'd10000))
    else $error("Humidity result is above full scale.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (temperature_centi_i >= -15'sd4500 && temperature_centi_i <= 15'sd13000))
    else $error("Temperature result is out of range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("A stalled result item was withdrawn.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(temperature_centi_i) && $stable(humidity_centi_i) && $stable(status_i)))
    else $error("A stalled result item changed.");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_i         (result_o.valid),
  .out_ready_i         (result_o.ready),
  .temperature_centi_i (result_o.temperature_centi),
  .humidity_centi_i    (result_o.humidity_centi),
  .status_i            (result_o.status)
);

`default_nettype wire

>>> tb/sv/humidity_sensor_frame_decoder_tb.sv
// Self-checking testbench for the humidity sensor frame decoder.
// Drives sensor reply bytes, predicts each reading and compares it to the block's output.
// Depends on hsfd_pkg, the hsfd_in_if and hsfd_out_if interfaces and the decoder top level.
`default_nettype none

module humidity_sensor_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsfd_pkg::*;

  localparam int CycleLimit   = 200_000;
  localparam int PhaseItems   = 170;
  localparam int DrainCycles  = 8;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic        [13:0] humidity_centi;
    logic        [1:0]  status;
  } reading_t;

  class sensor_reading_predictor;
    logic [2:0]  byte_pos;
    logic [7:0]  crc_acc;
    logic [7:0]  high_byte;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
    logic        temp_crc_bad;
    reading_t    pending_readings[$];
    int          mismatch_count;

    function new();
      byte_pos     = POS_T_HI;
      crc_acc      = 8'hFF;
      high_byte    = '0;
      temp_raw     = '0;
      hum_raw      = '0;
      temp_crc_bad = 1'b0;
      mismatch_count = 0;
    endfunction

    static function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      repeat (8) c = c[7] ? ((c << 1) ^ 8'h31) : (c << 1);
      return c;
    endfunction

    function void accept_byte(logic [7:0] b, logic start);
      logic [2:0] pos;
      int         t_scaled;
      int         h_scaled;
      int         t_offset;
      reading_t   r;
      pos = start ? POS_T_HI : byte_pos;
      case (pos)
        POS_T_HI, POS_H_HI: begin
          crc_acc   = crc_step(8'hFF, b);
          high_byte = b;
          byte_pos  = pos + 3'd1;
        end
        POS_T_LO: begin
          crc_acc  = crc_step(crc_acc, b);
          temp_raw = {high_byte, b};
          byte_pos = POS_T_CRC;
        end
        POS_T_CRC: begin
          temp_crc_bad = (crc_acc != b);
          byte_pos     = POS_H_HI;
        end
        POS_H_LO: begin
          crc_acc  = crc_step(crc_acc, b);
          hum_raw  = {high_byte, b};
          byte_pos = POS_H_CRC;
        end
        POS_H_CRC: begin
          t_scaled = (17500 * int'(temp_raw)) / 65535;
          h_scaled = (10000 * int'(hum_raw)) / 65535;
          t_offset = t_scaled - 4500;
          r.temperature_centi = t_offset[14:0];
          r.humidity_centi    = h_scaled[13:0];
          if (temp_crc_bad) r.status = STATUS_T_CRC;
          else if (crc_acc != b) r.status = STATUS_H_CRC;
          else r.status = STATUS_OK;
          pending_readings.push_back(r);
          byte_pos = POS_T_HI;
        end
        default: byte_pos = POS_T_HI;
      endcase
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected reading temp %0d hum %0d status %0d", $time,
                 got.temperature_centi, got.humidity_centi, got.status);
        mismatch_count++;
        return;
      end
      want = pending_readings.pop_front();
      if (got.temperature_centi !== want.temperature_centi) begin
        $display("%0t: temperature_centi expected %0d got %0d", $time,
                 want.temperature_centi, got.temperature_centi);
        mismatch_count++;
      end
      if (got.humidity_centi !== want.humidity_centi) begin
        $display("%0t: humidity_centi expected %0d got %0d", $time,
                 want.humidity_centi, got.humidity_centi);
        mismatch_count++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        mismatch_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  int   sent_count = 0;
  int   send_idle_pct = 35;
  int   recv_idle_pct = 50;

  sensor_reading_predictor readings = new();

  hsfd_in_if  byte_if ();
  hsfd_out_if reading_if ();

  humidity_sensor_frame_decoder DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .data_i  (byte_if),
    .result_o(reading_if)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[humidity_sensor_frame_decoder] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    reading_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && reading_if.valid && reading_if.ready) begin
      readings.check_reading({reading_if.temperature_centi, reading_if.humidity_centi,
                              reading_if.status});
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid       <= 1'b1;
    byte_if.data_byte   <= b;
    byte_if.frame_start <= start;
    do @(posedge clk); while (!byte_if.ready);
    readings.accept_byte(b, start);
    sent_count++;
  endtask

  task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                            input logic [7:0] t_crc_flip, input logic [7:0] h_crc_flip,
                            input logic start, input int n_bytes);
    logic [7:0] frame_bytes[6];
    frame_bytes[0] = t_raw[15:8];
    frame_bytes[1] = t_raw[7:0];
    frame_bytes[2] = sensor_reading_predictor::crc_step(
                       sensor_reading_predictor::crc_step(8'hFF, t_raw[15:8]), t_raw[7:0])
                     ^ t_crc_flip;
    frame_bytes[3] = h_raw[15:8];
    frame_bytes[4] = h_raw[7:0];
    frame_bytes[5] = sensor_reading_predictor::crc_step(
                       sensor_reading_predictor::crc_step(8'hFF, h_raw[15:8]), h_raw[7:0])
                     ^ h_crc_flip;
    for (int i = 0; i < n_bytes; i++) send_byte(frame_bytes[i], (i == 0) ? start : 1'b0);
  endtask

  task automatic wait_for_readings();
    byte_if.valid <= 1'b0;
    do @(posedge clk); while (readings.pending_readings.size() != 0);
  endtask

  task automatic random_traffic(input int target);
    int         kind;
    logic [7:0] t_flip;
    logic [7:0] h_flip;
    while (sent_count < target) begin
      kind   = $urandom_range(99);
      t_flip = ($urandom_range(99) < 20) ? 8'($urandom_range(1, 255)) : 8'h00;
      h_flip = ($urandom_range(99) < 20) ? 8'($urandom_range(1, 255)) : 8'h00;
      if (kind < 75) begin
        send_frame(16'($urandom), 16'($urandom), t_flip, h_flip,
                   ($urandom_range(99) < 70), 6);
      end else if (kind < 90) begin
        send_frame(16'($urandom), 16'($urandom), t_flip, h_flip,
                   1'($urandom_range(1)), $urandom_range(1, 5));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    byte_if.valid       <= 1'b0;
    byte_if.data_byte   <= 8'h00;
    byte_if.frame_start <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 1'b1, 6);
    send_frame(16'hFFFF, 16'hFFFF, 8'hFF, 8'h01, 1'b0, 6);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_frame(16'h8000, 16'h1234, 8'h00, 8'h80, 1'b1, 6);
    send_frame(16'h6666, 16'hFFFF, 8'h10, 8'h00, 1'b0, 6);

    random_traffic(sent_count + PhaseItems);
    wait_for_readings();

    send_idle_pct = 50;
    recv_idle_pct = 35;
    random_traffic(sent_count + PhaseItems);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(sent_count + PhaseItems);

    wait_for_readings();
    repeat (DrainCycles) @(posedge clk);
    if (readings.mismatch_count == 0) begin
      $display("[humidity_sensor_frame_decoder] OK");
    end else begin
      $display("[humidity_sensor_frame_decoder] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> humidity_sensor_frame_decoder.f
src/hsfd_pkg.sv
src/hsfd_if.sv
src/hsfd_framer.sv
src/hsfd_convert.sv
src/humidity_sensor_frame_decoder.sv
src/hsfd_checker.sv
tb/sv/humidity_sensor_frame_decoder_tb.sv
